FILE: src/krt_pkg.sv
package krt_pkg;

  localparam int unsigned RecWords = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned RecW     = RecWords * WordW;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_READ = 2'd2,
    ACT_LIST = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_MISS  = 3'd3,
    ST_FLOOR = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_RD,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESULT,
    S_WAIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clr_idx;
    logic       inc_idx;
    logic       rd_idx;
    logic       rd_next;
    logic       wr_add;
    logic       wr_shift;
    logic       inc_count;
    logic       dec_count;
    logic       load_out;
    logic       out_rec;
    logic       out_key;
    logic [2:0] status;
    logic       last;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic idx_end;
    logic next_end;
    logic full;
    logic empty;
    logic at_floor;
    logic out_busy;
  } stat_t;

endpackage

FILE: src/keyed_record_table_core.sv
// Add, delete and read search the table entry by entry in read and compare states.
// Delete then shifts each later entry down (read, write); list gives one beat per entry.
// One item is handled at a time; the result beat is held in an output register.
// Reset clears the entry count and the controller; record storage holds no reset.
// The delete floor resets to three.
module keyed_record_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] year_in_i,
  input  logic [31:0] item1_id_in_i,
  input  logic [31:0] item1_value_in_i,
  input  logic [31:0] item2_id_in_i,
  input  logic [31:0] item2_value_in_i,
  input  logic [31:0] item3_id_in_i,
  input  logic [31:0] item3_value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic        is_full_o,
  output logic [31:0] key_out_o,
  output logic [31:0] year_out_o,
  output logic [31:0] item1_id_out_o,
  output logic [31:0] item1_value_out_o,
  output logic [31:0] item2_id_out_o,
  output logic [31:0] item2_value_out_o,
  output logic [31:0] item3_id_out_o,
  output logic [31:0] item3_value_out_o,
  output logic        last_o
);
  import krt_pkg::*;

  logic [4:0]      floor_q;
  ctrl_t           ctrl;
  stat_t           stat;
  state_e          state;
  logic [RecW-1:0] rec;
  logic            in_acc;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, floor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= 5'd3;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      floor_q <= pwdata[4:0];
    end
  end

  assign in_acc = in_valid_i & in_ready_o;

  krt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .action_i  (action_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .state_o   (state)
  );

  krt_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_accept_i     (in_acc),
    .key_i           (key_i),
    .year_in_i       (year_in_i),
    .item1_id_in_i   (item1_id_in_i),
    .item1_value_in_i(item1_value_in_i),
    .item2_id_in_i   (item2_id_in_i),
    .item2_value_in_i(item2_value_in_i),
    .item3_id_in_i   (item3_id_in_i),
    .item3_value_in_i(item3_value_in_i),
    .delete_floor_i  (floor_q),
    .ctrl_i          (ctrl),
    .state_i         (state),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .is_full_o       (is_full_o),
    .rec_o           (rec),
    .last_o          (last_o)
  );

  assign key_out_o         = rec[31:0];
  assign year_out_o        = rec[63:32];
  assign item1_id_out_o    = rec[95:64];
  assign item1_value_out_o = rec[127:96];
  assign item2_id_out_o    = rec[159:128];
  assign item2_value_out_o = rec[191:160];
  assign item3_id_out_o    = rec[223:192];
  assign item3_value_out_o = rec[255:224];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result beat changed while stalled");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state == S_IDLE)
    else $error("input taken outside idle");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= 5'(TABLE_DEPTH))
    else $error("entry count exceeds depth");

endmodule

FILE: src/krt_ram.sv
module krt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/krt_ctrl.sv
module krt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  krt_pkg::stat_t      stat_i,
  output krt_pkg::ctrl_t      ctrl_o,
  output krt_pkg::state_e     state_o
);
  import krt_pkg::*;

  state_e  state_q, state_d;
  action_e act_q, act_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_ADD;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign state_o    = state_q;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = action_e'(action_i);
          if (action_e'(action_i) == ACT_LIST) begin
            state_d = stat_i.empty ? S_RESULT : S_LIST_RD;
          end else if (action_e'(action_i) == ACT_ADD && stat_i.full) begin
            state_d = S_RESULT;
          end else if (action_e'(action_i) == ACT_DEL && stat_i.at_floor) begin
            state_d = S_RESULT;
          end else begin
            state_d = stat_i.empty ? S_DECIDE : S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat_i.hit || stat_i.idx_end) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_DECIDE: begin
        if (act_q == ACT_DEL && stat_i.hit) begin
          state_d = stat_i.idx_end ? S_RESULT : S_SHIFT_RD;
        end else if (act_q == ACT_READ && stat_i.hit) begin
          state_d = S_READ_RD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = stat_i.next_end ? S_RESULT : S_SHIFT_RD;
      S_READ_RD:  state_d = S_RESULT;
      S_LIST_RD:  state_d = S_LIST_OUT;
      S_LIST_OUT: begin
        if (!stat_i.out_busy) begin
          state_d = stat_i.idx_end ? S_IDLE : S_LIST_RD;
        end
      end
      S_RESULT:   state_d = stat_i.out_busy ? S_RESULT : S_WAIT;
      S_WAIT:     state_d = stat_i.out_busy ? S_WAIT : S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      S_IDLE: begin
        ctrl_o.clr_idx = 1'b1;
        if (in_valid_i) begin
          if (action_e'(action_i) == ACT_LIST) begin
            ctrl_o.status = ST_OK;
          end else if (action_e'(action_i) == ACT_ADD && stat_i.full) begin
            ctrl_o.status = ST_FULL;
          end else if (action_e'(action_i) == ACT_DEL && stat_i.at_floor) begin
            ctrl_o.status = ST_FLOOR;
          end
        end
      end
      S_SRCH_RD: ctrl_o.rd_idx = 1'b1;
      S_SRCH_CMP: begin
        if (!stat_i.hit && !stat_i.idx_end) begin
          ctrl_o.inc_idx = 1'b1;
        end
      end
      S_DECIDE: begin
        case (act_q)
          ACT_ADD: begin
            if (stat_i.hit) begin
              ctrl_o.status = ST_DUP;
            end else begin
              ctrl_o.wr_add    = 1'b1;
              ctrl_o.inc_count = 1'b1;
              ctrl_o.status    = ST_OK;
            end
          end
          ACT_DEL: begin
            if (stat_i.hit) begin
              ctrl_o.status = ST_OK;
              if (stat_i.idx_end) begin
                ctrl_o.dec_count = 1'b1;
              end
            end else begin
              ctrl_o.status = ST_MISS;
            end
          end
          ACT_READ: begin
            ctrl_o.status = stat_i.hit ? ST_OK : ST_MISS;
            ctrl_o.rd_idx = 1'b1;
          end
          default: ctrl_o.status = ST_OK;
        endcase
      end
      S_SHIFT_RD: ctrl_o.rd_next = 1'b1;
      S_SHIFT_WR: begin
        ctrl_o.wr_shift = 1'b1;
        ctrl_o.inc_idx  = 1'b1;
        if (stat_i.next_end) begin
          ctrl_o.dec_count = 1'b1;
        end
      end
      S_READ_RD:  ctrl_o.status = ST_OK;
      S_LIST_RD:  ctrl_o.rd_idx = 1'b1;
      S_LIST_OUT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.load_out = 1'b1;
          ctrl_o.out_key  = 1'b1;
          ctrl_o.last     = stat_i.idx_end;
          ctrl_o.inc_idx  = 1'b1;
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          ctrl_o.load_out = 1'b1;
          ctrl_o.out_rec  = (act_q == ACT_READ);
          ctrl_o.last     = 1'b1;
        end
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

FILE: src/krt_dp.sv
module krt_dp #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_accept_i,
  input  logic [31:0]                 key_i,
  input  logic [31:0]                 year_in_i,
  input  logic [31:0]                 item1_id_in_i,
  input  logic [31:0]                 item1_value_in_i,
  input  logic [31:0]                 item2_id_in_i,
  input  logic [31:0]                 item2_value_in_i,
  input  logic [31:0]                 item3_id_in_i,
  input  logic [31:0]                 item3_value_in_i,
  input  logic [4:0]                  delete_floor_i,
  input  krt_pkg::ctrl_t              ctrl_i,
  input  krt_pkg::state_e             state_i,
  output krt_pkg::stat_t              stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [4:0]                  entry_count_o,
  output logic                        is_full_o,
  output logic [krt_pkg::RecW-1:0]    rec_o,
  output logic                        last_o
);
  import krt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              hit_q, hit_d;
  logic [2:0]        st_q, st_d;
  logic [RecW-1:0]   in_rec_q;
  logic [RecW-1:0]   rd_data;
  logic [IdxW-1:0]   raddr, waddr;
  logic [RecW-1:0]   wdata;
  logic              we;
  logic              ov_q;
  logic [2:0]        ost_q;
  logic [4:0]        ocnt_q;
  logic              ofull_q, olast_q;
  logic [RecW-1:0]   orec_q;
  logic [CntW-1:0]   idx_ext;
  logic [CntW-1:0]   count_new;

  assign idx_ext = CntW'(idx_q);

  always_comb begin
    raddr = idx_q;
    if (ctrl_i.rd_next) begin
      raddr = idx_q + IdxW'(1);
    end
    waddr = ctrl_i.wr_add ? count_q[IdxW-1:0] : idx_q;
    wdata = ctrl_i.wr_add ? in_rec_q : rd_data;
    we    = ctrl_i.wr_add | ctrl_i.wr_shift;
  end

  krt_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  always_comb begin
    count_d = count_q;
    if (ctrl_i.inc_count) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.dec_count) begin
      count_d = count_q - CntW'(1);
    end
    idx_d = idx_q;
    if (ctrl_i.clr_idx) begin
      idx_d = '0;
    end else if (ctrl_i.inc_idx) begin
      idx_d = idx_q + IdxW'(1);
    end
    hit_d = hit_q;
    if (ctrl_i.clr_idx) begin
      hit_d = 1'b0;
    end else if (state_i == S_SRCH_CMP) begin
      hit_d = (rd_data[WordW-1:0] == in_rec_q[WordW-1:0]);
    end
    st_d = st_q;
    if ((state_i == S_IDLE && in_accept_i) || state_i == S_DECIDE) begin
      st_d = ctrl_i.status;
    end
  end

  assign count_new = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      st_q    <= ST_OK;
      ov_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      st_q    <= st_d;
      if (ctrl_i.load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      in_rec_q <= {item3_value_in_i, item3_id_in_i, item2_value_in_i, item2_id_in_i,
                   item1_value_in_i, item1_id_in_i, year_in_i, key_i};
    end
    if (ctrl_i.load_out) begin
      ost_q   <= ctrl_i.out_key ? ST_OK : st_q;
      ocnt_q  <= 5'(count_new);
      ofull_q <= (count_new == CntW'(TableDepth));
      olast_q <= ctrl_i.last;
      if (ctrl_i.out_key) begin
        orec_q <= {{(RecW - WordW){1'b0}}, rd_data[WordW-1:0]};
      end else if (st_q == ST_OK && hit_q && ctrl_i.out_rec
                   && in_rec_q[WordW-1:0] == rd_data[WordW-1:0]) begin
        orec_q <= rd_data;
      end else begin
        orec_q <= '0;
      end
    end
  end

  assign stat_o.hit      = hit_d;
  assign stat_o.idx_end  = (idx_ext + CntW'(1) >= count_q);
  assign stat_o.next_end = (idx_ext + CntW'(2) >= count_q);
  assign stat_o.full     = (count_q >= CntW'(TableDepth));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.at_floor = (CntW'(count_q) <= CntW'(delete_floor_i)) ||
                           (CntW < 5 && delete_floor_i >= 5'(TableDepth));
  assign stat_o.out_busy = ov_q & ~out_ready_i;

  assign out_valid_o   = ov_q;
  assign status_o      = ost_q;
  assign entry_count_o = ocnt_q;
  assign is_full_o     = ofull_q;
  assign rec_o         = orec_q;
  assign last_o        = olast_q;

endmodule
